// ----- sv/pixel_mask_collision_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the pixel mask collision block
// Shared property forms used by the top-level assertions.
// ---------------------------------------------------------------------------
`ifndef PIXEL_MASK_COLLISION_MACROS_SVH
`define PIXEL_MASK_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PMC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pmc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_pkg
// Constants, codes, types and helpers shared by the collision block files.
// ---------------------------------------------------------------------------
package pmc_pkg;

  // Mask geometry.
  localparam int MAX_SIDE    = 64;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int BANKS       = MAX_SIDE;
  localparam int BANK_W      = $clog2(BANKS);
  localparam int IDX_W       = 12;
  localparam int WORD_W      = IDX_W - BANK_W;
  localparam int WORDS       = 1 << WORD_W;
  localparam int PROD_W      = 2 * SIDE_W;

  // Field widths.
  localparam int CMD_W       = 2;
  localparam int PIX_W       = 8;
  localparam int POS_W       = 16;
  localparam int EDGE_W      = POS_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_B  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_B = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic edge_calc;
    logic test_calc;
    logic size_calc;
    logic base_calc;
    logic scan_issue;
  } pmc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic box;
    logic empty;
    logic row_last;
    logic hit;
  } pmc_stat_t;

  // Size registers saturate at the largest mask side.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v > CFG_DATA_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- sv/pmc_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_in_if
// Input channel: load and query commands with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pmc_in_if import pmc_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        pixel_index;
  logic [PIX_W-1:0]        pixel_value;
  logic signed [POS_W-1:0] pos_ax;
  logic signed [POS_W-1:0] pos_ay;
  logic signed [POS_W-1:0] pos_bx;
  logic signed [POS_W-1:0] pos_by;
  logic                    box_only;

  modport source (
    output valid, cmd, pixel_index, pixel_value, pos_ax, pos_ay, pos_bx, pos_by, box_only,
    input  ready
  );

  modport sink (
    input  valid, cmd, pixel_index, pixel_value, pos_ax, pos_ay, pos_bx, pos_by, box_only,
    output ready
  );

endinterface

// ----- sv/pmc_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_out_if
// Result channel: one collision flag per query with valid/ready handshake.
// ---------------------------------------------------------------------------
interface pmc_out_if import pmc_pkg::*; ();

  logic valid;
  logic ready;
  logic collides;

  modport source (
    output valid, collides,
    input  ready
  );

  modport sink (
    input  valid, collides,
    output ready
  );

endinterface

// ----- sv/pixel_mask_collision.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_mask_collision
// Pixel-exact collision test between two one-bit masks loaded pixel by pixel.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Contents
//  in_ch   | in        | valid/ready      | load A, load B or query command
//  out_ch  | out       | valid/ready      | collides flag, one per query
//  cfg_*   | in        | write enable     | mask width and height registers
//
//  A load is accepted back to back while the block is idle. A query runs the
//  edge, test, size and base states, ending after size if rejected or in box
//  mode and after base if the overlap is empty; otherwise it scans, drains and
//  flushes, reading one overlap row per cycle from 64 single-bit banks per mask.
//  Reset is synchronous; the mask stores are not cleared and need no sweep.
//  The result register frees the controller; a stalled result holds the next
//  query in its final state until the transfer.
// ---------------------------------------------------------------------------
module pixel_mask_collision import pmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pmc_in_if.sink                in_ch,
  pmc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "pixel_mask_collision_macros.svh"

  pmc_cmd_t  cmd;
  pmc_stat_t stat;
  logic      in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  // Controller.
  pmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_cmd       (in_ch.cmd),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_collides (out_ch.collides),
    .out_ready    (out_ch.ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Datapath.
  pmc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_fire        (in_fire),
    .in_cmd         (in_ch.cmd),
    .in_pixel_index (in_ch.pixel_index),
    .in_pixel_value (in_ch.pixel_value),
    .in_pos_ax      (in_ch.pos_ax),
    .in_pos_ay      (in_ch.pos_ay),
    .in_pos_bx      (in_ch.pos_bx),
    .in_pos_by      (in_ch.pos_by),
    .in_box_only    (in_ch.box_only),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // A query transfer makes the block busy in the next cycle.
  `PMC_ASSERT_NXT(a_query_busy, clk, rst_n, in_fire && (in_ch.cmd == CMD_QUERY), !in_ch.ready, "query transfer did not make the block busy")

  // The row scan only starts for an overlapping pixel-exact query.
  `PMC_ASSERT_IMP(a_scan_start, clk, rst_n, cmd.base_calc, !stat.reject && !stat.box && !stat.empty, "row scan started for a rejected or box-only or empty query")

  // Rows are only issued while the overlap is non-empty.
  `PMC_ASSERT_IMP(a_scan_rows, clk, rst_n, cmd.scan_issue, !stat.empty && !in_ch.ready, "row issued with an empty overlap or while idle")

endmodule

// ----- sv/pmc_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module pmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pmc_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_ctrl
// Controller: sequences a query through the datapath and owns the result register.
// ---------------------------------------------------------------------------
module pmc_ctrl import pmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  output logic             out_collides,
  input  logic             out_ready,
  output pmc_cmd_t         cmd,
  input  pmc_stat_t        stat
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE  = 4'd1;
  localparam logic [3:0] S_TEST  = 4'd2;
  localparam logic [3:0] S_SIZE  = 4'd3;
  localparam logic [3:0] S_BASE  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_FLUSH = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       collides_r, collides_nxt;
  logic       in_fire;

  assign in_ready     = (state_r == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_collides = collides_r;

  // Next-state and command decode.
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    collides_nxt  = collides_r;
    cmd           = '0;

    // The output register empties on a transfer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_cmd == CMD_QUERY)) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd.edge_calc = 1'b1;
        state_nxt     = S_TEST;
      end
      S_TEST: begin
        cmd.test_calc = 1'b1;
        state_nxt     = S_SIZE;
      end
      S_SIZE: begin
        if (stat.reject) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (stat.box) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.size_calc = 1'b1;
          state_nxt     = S_BASE;
        end
      end
      S_BASE: begin
        if (stat.empty) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.base_calc = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.row_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        res_nxt   = stat.hit;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hand the answer over once the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          collides_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    collides_r <= collides_nxt;
  end

endmodule

// ----- sv/pmc_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmc_dp
// Datapath: size registers, banked mask stores, box test and row scan.
// ---------------------------------------------------------------------------
module pmc_dp import pmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pmc_cmd_t                cmd,
  output pmc_stat_t               stat,
  input  logic                    in_fire,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [IDX_W-1:0]        in_pixel_index,
  input  logic [PIX_W-1:0]        in_pixel_value,
  input  logic signed [POS_W-1:0] in_pos_ax,
  input  logic signed [POS_W-1:0] in_pos_ay,
  input  logic signed [POS_W-1:0] in_pos_bx,
  input  logic signed [POS_W-1:0] in_pos_by,
  input  logic                    in_box_only,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Size registers, saturated on write.
  logic [SIDE_W-1:0] wa_r, ha_r, wb_r, hb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wa_r <= SIDE_W'(1);
      ha_r <= SIDE_W'(1);
      wb_r <= SIDE_W'(1);
      hb_r <= SIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_A:  wa_r <= clamp_side(cfg_data);
        CFG_HEIGHT_A: ha_r <= clamp_side(cfg_data);
        CFG_WIDTH_B:  wb_r <= clamp_side(cfg_data);
        CFG_HEIGHT_B: hb_r <= clamp_side(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Query capture.
  logic signed [POS_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic                    box_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ax_r  <= in_pos_ax;
      ay_r  <= in_pos_ay;
      bx_r  <= in_pos_bx;
      by_r  <= in_pos_by;
      box_r <= in_box_only;
    end
  end

  // Right and bottom edges, and the overlap's top-left corner.
  logic signed [EDGE_W-1:0] axe, aye, bxe, bye;
  logic signed [EDGE_W-1:0] ra_r, rb_r, ba_r, bb_r, ol_r, ot_r;

  assign axe = {ax_r[POS_W-1], ax_r};
  assign aye = {ay_r[POS_W-1], ay_r};
  assign bxe = {bx_r[POS_W-1], bx_r};
  assign bye = {by_r[POS_W-1], by_r};

  always_ff @(posedge clk) begin
    if (cmd.edge_calc) begin
      ra_r <= axe + $signed({{(EDGE_W-SIDE_W){1'b0}}, wa_r});
      rb_r <= bxe + $signed({{(EDGE_W-SIDE_W){1'b0}}, wb_r});
      ba_r <= aye + $signed({{(EDGE_W-SIDE_W){1'b0}}, ha_r});
      bb_r <= bye + $signed({{(EDGE_W-SIDE_W){1'b0}}, hb_r});
      ol_r <= (axe > bxe) ? axe : bxe;
      ot_r <= (aye > bye) ? aye : bye;
    end
  end

  // Box rejection with strict compares, overlap limits and mask offsets.
  logic                     reject_r;
  logic signed [EDGE_W-1:0] minx_r, miny_r;
  logic [SIDE_W-1:0]        offax_r, offbx_r, rowa0_r, rowb0_r;
  logic [EDGE_W-1:0]        d_offax, d_offbx, d_rowa0, d_rowb0;

  assign d_offax = ol_r - axe;
  assign d_offbx = ol_r - bxe;
  assign d_rowa0 = ot_r - aye;
  assign d_rowb0 = ot_r - bye;

  always_ff @(posedge clk) begin
    if (cmd.test_calc) begin
      reject_r <= (ba_r < bye) || (aye > bb_r) || (ra_r < bxe) || (axe > rb_r);
      minx_r   <= (ra_r < rb_r) ? ra_r : rb_r;
      miny_r   <= (ba_r < bb_r) ? ba_r : bb_r;
      offax_r  <= d_offax[SIDE_W-1:0];
      offbx_r  <= d_offbx[SIDE_W-1:0];
      rowa0_r  <= d_rowa0[SIDE_W-1:0];
      rowb0_r  <= d_rowb0[SIDE_W-1:0];
    end
  end

  // Overlap extent; both lie in zero to the mask side once the boxes overlap.
  logic [SIDE_W-1:0] ow_r, oh_r;
  logic [EDGE_W-1:0] d_ow, d_oh;

  assign d_ow = minx_r - ol_r;
  assign d_oh = miny_r - ot_r;

  always_ff @(posedge clk) begin
    if (cmd.size_calc) begin
      ow_r <= d_ow[SIDE_W-1:0];
      oh_r <= d_oh[SIDE_W-1:0];
    end
  end

  // Row start addresses: first row by multiply, later rows by adding the width.
  logic [PROD_W-1:0] base_a_r, base_b_r;
  logic [SIDE_W-1:0] row_r;

  always_ff @(posedge clk) begin
    if (cmd.base_calc) begin
      base_a_r <= (rowa0_r * wa_r) + {{(PROD_W-SIDE_W){1'b0}}, offax_r};
      base_b_r <= (rowb0_r * wb_r) + {{(PROD_W-SIDE_W){1'b0}}, offbx_r};
      row_r    <= '0;
    end else if (cmd.scan_issue) begin
      base_a_r <= base_a_r + {{(PROD_W-SIDE_W){1'b0}}, wa_r};
      base_b_r <= base_b_r + {{(PROD_W-SIDE_W){1'b0}}, wb_r};
      row_r    <= row_r + SIDE_W'(1);
    end
  end

  // Banked stores: bank b holds the pixels whose address ends in b.
  logic [IDX_W-1:0]  start_a, start_b;
  logic [BANKS-1:0]  rd_a, rd_b;
  logic              load_a, load_b, solid;

  assign start_a = base_a_r[IDX_W-1:0];
  assign start_b = base_b_r[IDX_W-1:0];
  assign load_a  = in_fire && (in_cmd == CMD_LOAD_A);
  assign load_b  = in_fire && (in_cmd == CMD_LOAD_B);
  assign solid   = (in_pixel_value != '0);

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [WORD_W-1:0] raddr_a, raddr_b;
    logic              we_a, we_b;

    // A bank below the start offset serves the next word of the run.
    assign raddr_a = start_a[IDX_W-1:BANK_W] +
                     WORD_W'(BANK_W'(b) < start_a[BANK_W-1:0]);
    assign raddr_b = start_b[IDX_W-1:BANK_W] +
                     WORD_W'(BANK_W'(b) < start_b[BANK_W-1:0]);
    assign we_a    = load_a && (in_pixel_index[BANK_W-1:0] == BANK_W'(b));
    assign we_b    = load_b && (in_pixel_index[BANK_W-1:0] == BANK_W'(b));

    pmc_ram #(.WIDTH(1), .DEPTH(WORDS)) u_ram_a (
      .clk   (clk),
      .we    (we_a),
      .waddr (in_pixel_index[IDX_W-1:BANK_W]),
      .wdata (solid),
      .raddr (raddr_a),
      .rdata (rd_a[b])
    );

    pmc_ram #(.WIDTH(1), .DEPTH(WORDS)) u_ram_b (
      .clk   (clk),
      .we    (we_b),
      .waddr (in_pixel_index[IDX_W-1:BANK_W]),
      .wdata (solid),
      .raddr (raddr_b),
      .rdata (rd_b[b])
    );
  end

  // Read stage bookkeeping, aligned with the registered bank data.
  logic              rd_valid_r;
  logic [BANK_W-1:0] rot_a_r, rot_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    rot_a_r <= start_a[BANK_W-1:0];
    rot_b_r <= start_b[BANK_W-1:0];
  end

  // Rotate each row into column order, then test the overlap width.
  logic [2*BANKS-1:0] dbl_a, dbl_b;
  logic [BANKS-1:0]   row_a, row_b, width_mask;
  logic               row_hit;

  assign dbl_a      = {rd_a, rd_a} >> rot_a_r;
  assign dbl_b      = {rd_b, rd_b} >> rot_b_r;
  assign row_a      = dbl_a[BANKS-1:0];
  assign row_b      = dbl_b[BANKS-1:0];
  assign width_mask = (ow_r >= SIDE_W'(BANKS)) ? '1 :
                      ((BANKS'(1) << ow_r[BANK_W-1:0]) - BANKS'(1));
  assign row_hit    = |(row_a & row_b & width_mask);

  // Hit accumulator over the scanned rows.
  logic hit_r;

  always_ff @(posedge clk) begin
    if (cmd.base_calc) begin
      hit_r <= 1'b0;
    end else if (rd_valid_r) begin
      hit_r <= hit_r | row_hit;
    end
  end

  // Status toward the controller.
  assign stat.reject   = reject_r;
  assign stat.box      = box_r;
  assign stat.empty    = (ow_r == '0) || (oh_r == '0);
  assign stat.row_last = ((row_r + SIDE_W'(1)) == oh_r);
  assign stat.hit      = hit_r;

endmodule

// ----- dv/pixel_mask_collision_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_mask_collision_tb
// Self-checking bench for the two-mask collision block. Pixel loads and
// collision queries go in over the command channel. A scoreboard keeps its
// own copy of both masks and of the size registers, predicts every collision
// flag and compares it with each result transfer, in order.
// ---------------------------------------------------------------------------
import pmc_pkg::*;

// One command as offered on the input channel.
typedef struct {
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        pixel_index;
  logic [PIX_W-1:0]        pixel_value;
  logic signed [POS_W-1:0] pos_ax;
  logic signed [POS_W-1:0] pos_ay;
  logic signed [POS_W-1:0] pos_bx;
  logic signed [POS_W-1:0] pos_by;
  logic                    box_only;
} pmc_command_t;

// Mirror of the mask stores and size registers, plus the expected flags.
class collision_scoreboard;
  logic [CFG_DATA_W-1:0] size_reg[4];
  bit                    mask_a[MAX_SIDE*MAX_SIDE];
  bit                    mask_b[MAX_SIDE*MAX_SIDE];
  bit                    pending_collides[$];
  int                    errors;
  int                    loads;
  int                    queries;
  int                    ignored;
  int                    checked;

  function new();
    foreach (size_reg[i]) size_reg[i] = 1;
  endfunction

  function void set_size(input int idx, input logic [CFG_DATA_W-1:0] v);
    size_reg[idx] = v;
  endfunction

  // A size above the largest side saturates.
  function int side(input int idx);
    int v;
    v = size_reg[idx];
    return (v > MAX_SIDE) ? MAX_SIDE : v;
  endfunction

  // Strict bounding-box rejection; touching boxes pass. Returns the overlap
  // rectangle, which is empty when the boxes only touch.
  function bit box_overlap(input pmc_command_t it, output int ol, output int ot,
                           output int ow, output int oh);
    int ax, ay, bx, by, ra, rb, ba, bb;
    ax = it.pos_ax;
    ay = it.pos_ay;
    bx = it.pos_bx;
    by = it.pos_by;
    ra = ax + side(CFG_WIDTH_A);
    ba = ay + side(CFG_HEIGHT_A);
    rb = bx + side(CFG_WIDTH_B);
    bb = by + side(CFG_HEIGHT_B);
    ol = (ax > bx) ? ax : bx;
    ot = (ay > by) ? ay : by;
    ow = ((ra < rb) ? ra : rb) - ol;
    oh = ((ba < bb) ? ba : bb) - ot;
    return !(ba < by || ay > bb || ra < bx || ax > rb);
  endfunction

  function bit predict_collision(input pmc_command_t it);
    int ol, ot, ow, oh, wa, wb, ia, ib;
    if (!box_overlap(it, ol, ot, ow, oh)) return 1'b0;
    if (it.box_only) return 1'b1;
    wa = side(CFG_WIDTH_A);
    wb = side(CFG_WIDTH_B);
    for (int y = 0; y < oh; y++) begin
      for (int x = 0; x < ow; x++) begin
        ia = (ot - int'(it.pos_ay) + y) * wa + (ol - int'(it.pos_ax) + x);
        ib = (ot - int'(it.pos_by) + y) * wb + (ol - int'(it.pos_bx) + x);
        if (ia < MAX_SIDE*MAX_SIDE && ib < MAX_SIDE*MAX_SIDE && mask_a[ia] && mask_b[ib])
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Called for every accepted command transfer.
  function void note_command(input pmc_command_t it);
    case (it.cmd)
      CMD_LOAD_A: begin
        mask_a[it.pixel_index] = (it.pixel_value != 0);
        loads++;
      end
      CMD_LOAD_B: begin
        mask_b[it.pixel_index] = (it.pixel_value != 0);
        loads++;
      end
      CMD_QUERY: begin
        pending_collides.push_back(predict_collision(it));
        queries++;
      end
      default: begin
        ignored++;
      end
    endcase
  endfunction

  // Called for every accepted result transfer.
  function void check_collides(input logic got);
    bit exp;
    if (pending_collides.size() == 0) begin
      errors++;
      $display("%0t: result with no query pending: expected none, actual collides=%0b",
               $time, got);
    end else begin
      exp = pending_collides.pop_front();
      checked++;
      if (got !== exp) begin
        errors++;
        $display("%0t: collides mismatch: expected %0b, actual %0b", $time, exp, got);
      end
    end
  endfunction
endclass

module pixel_mask_collision_tb;

  localparam int                CYCLE_LIMIT    = 1000000;
  localparam int                SETTLE_CYCLES  = 80;
  localparam int                RX_HOLD_CYCLES = 400;
  localparam int                NUM_PHASES     = 9;
  localparam int                STORE_DEPTH    = MAX_SIDE * MAX_SIDE;
  localparam int                PRIME_BUDGET   = 64;
  localparam logic [CMD_W-1:0]  CMD_UNUSED     = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmc_in_if  in_ch ();
  pmc_out_if out_ch ();

  collision_scoreboard sb = new();

  // Stimulus-side record of which pixels have been loaded since reset.
  bit loaded_a[STORE_DEPTH];
  bit loaded_b[STORE_DEPTH];

  int tx_idle_pct;
  int rx_idle_pct;
  int solid_pct;
  int size_settings;
  bit rx_hold;
  int cycle_count;

  // Size settings of the random phases and the number of random traffic steps in each.
  int phase_size[NUM_PHASES][4] = '{
    '{5, 4, 6, 3}, '{0, 3, 4, 0}, '{16, 16, 12, 20},
    '{3, 9, 2, 7}, '{64, 64, 64, 64}, '{33, 1, 1, 40},
    '{127, 100, 127, 65}, '{10, 12, 8, 8}, '{2, 2, 64, 3}
  };
  int phase_len[NUM_PHASES] = '{100, 100, 100, 100, 40, 100, 40, 100, 100};

  pixel_mask_collision dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               sb.pending_collides.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver: random backpressure, with one long hold when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_collides(out_ch.collides);
  end

  function automatic logic [PIX_W-1:0] pixel_byte();
    return ($urandom_range(0, 99) < solid_pct) ? PIX_W'($urandom_range(1, 255)) : '0;
  endfunction

  function automatic pmc_command_t load_item(input logic [CMD_W-1:0] cmd, input int idx,
                                              input logic [PIX_W-1:0] value);
    pmc_command_t it;
    it.cmd         = cmd;
    it.pixel_index = IDX_W'(idx);
    it.pixel_value = value;
    it.pos_ax      = POS_W'($urandom);
    it.pos_ay      = POS_W'($urandom);
    it.pos_bx      = POS_W'($urandom);
    it.pos_by      = POS_W'($urandom);
    it.box_only    = 1'($urandom);
    return it;
  endfunction

  function automatic pmc_command_t query_item(input int ax, input int ay, input int bx,
                                               input int by, input bit box_only);
    pmc_command_t it;
    it.cmd         = CMD_QUERY;
    it.pixel_index = IDX_W'($urandom);
    it.pixel_value = PIX_W'($urandom);
    it.pos_ax      = POS_W'(ax);
    it.pos_ay      = POS_W'(ay);
    it.pos_bx      = POS_W'(bx);
    it.pos_by      = POS_W'(by);
    it.box_only    = box_only;
    return it;
  endfunction

  function automatic pmc_command_t noise_item();
    pmc_command_t it;
    it = load_item(CMD_UNUSED, $urandom, PIX_W'($urandom));
    return it;
  endfunction

  // Offer one command, with random idle cycles ahead of it, and wait for the transfer.
  task automatic send_command(input pmc_command_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.pixel_index <= it.pixel_index;
    in_ch.pixel_value <= it.pixel_value;
    in_ch.pos_ax      <= it.pos_ax;
    in_ch.pos_ay      <= it.pos_ay;
    in_ch.pos_bx      <= it.pos_bx;
    in_ch.pos_by      <= it.pos_by;
    in_ch.box_only    <= it.box_only;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(it);
    if (it.cmd == CMD_LOAD_A) loaded_a[it.pixel_index] = 1'b1;
    if (it.cmd == CMD_LOAD_B) loaded_b[it.pixel_index] = 1'b1;
  endtask

  // Number of overlap pixels that would still have to be loaded for a query.
  function automatic int unloaded_count(input pmc_command_t it);
    int ol, ot, ow, oh, wa, wb, ia, ib, n;
    n = 0;
    if (!sb.box_overlap(it, ol, ot, ow, oh)) return 0;
    wa = sb.side(CFG_WIDTH_A);
    wb = sb.side(CFG_WIDTH_B);
    for (int y = 0; y < oh; y++) begin
      for (int x = 0; x < ow; x++) begin
        ia = (ot - int'(it.pos_ay) + y) * wa + (ol - int'(it.pos_ax) + x);
        ib = (ot - int'(it.pos_by) + y) * wb + (ol - int'(it.pos_bx) + x);
        if (!loaded_a[ia]) n++;
        if (!loaded_b[ib]) n++;
      end
    end
    return n;
  endfunction

  // Before a pixel-exact query, load every overlap pixel not yet written.
  task automatic prime_overlap(input pmc_command_t it);
    int ol, ot, ow, oh, wa, wb, ia, ib;
    if (!sb.box_overlap(it, ol, ot, ow, oh)) return;
    wa = sb.side(CFG_WIDTH_A);
    wb = sb.side(CFG_WIDTH_B);
    for (int y = 0; y < oh; y++) begin
      for (int x = 0; x < ow; x++) begin
        ia = (ot - int'(it.pos_ay) + y) * wa + (ol - int'(it.pos_ax) + x);
        ib = (ot - int'(it.pos_by) + y) * wb + (ol - int'(it.pos_bx) + x);
        if (!loaded_a[ia]) send_command(load_item(CMD_LOAD_A, ia, pixel_byte()));
        if (!loaded_b[ib]) send_command(load_item(CMD_LOAD_B, ib, pixel_byte()));
      end
    end
  endtask

  // Stop offering, wait for every pending result, then let the block go idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_collides.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four size registers, one per cycle.
  task automatic program_sizes(input int wa, input int ha, input int wb, input int hb);
    logic [CFG_DATA_W-1:0] v[4];
    v[CFG_WIDTH_A]  = CFG_DATA_W'(wa);
    v[CFG_HEIGHT_A] = CFG_DATA_W'(ha);
    v[CFG_WIDTH_B]  = CFG_DATA_W'(wb);
    v[CFG_HEIGHT_B] = CFG_DATA_W'(hb);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= v[i];
      @(posedge clk);
      sb.set_size(i, v[i]);
    end
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  // Mostly loads inside the masks and queries near each other, some noise.
  task automatic random_traffic(input int count);
    pmc_command_t     it;
    logic [CMD_W-1:0] cmd;
    int roll, wa, ha, wb, hb, area, idx, ax, ay, dx, dy;
    for (int n = 0; n < count; n++) begin
      wa   = sb.side(CFG_WIDTH_A);
      ha   = sb.side(CFG_HEIGHT_A);
      wb   = sb.side(CFG_WIDTH_B);
      hb   = sb.side(CFG_HEIGHT_B);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        cmd  = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
        area = (cmd == CMD_LOAD_A) ? wa * ha : wb * hb;
        if (area > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, area - 1);
        else idx = $urandom_range(0, STORE_DEPTH - 1);
        send_command(load_item(cmd, idx, pixel_byte()));
      end else if (roll < 95) begin
        if ($urandom_range(0, 99) < 12) begin
          it = query_item($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
        end else begin
          ax = int'($urandom_range(0, 64000)) - 32000;
          ay = int'($urandom_range(0, 64000)) - 32000;
          // Touching edges get extra weight.
          if ($urandom_range(0, 99) < 15) dx = $urandom_range(0, 1) ? wa : -wb;
          else dx = int'($urandom_range(0, wa + wb + 4)) - wb - 2;
          if ($urandom_range(0, 99) < 15) dy = $urandom_range(0, 1) ? ha : -hb;
          else dy = int'($urandom_range(0, ha + hb + 4)) - hb - 2;
          it = query_item(ax, ay, ax + dx, ay + dy, $urandom_range(0, 3) == 0);
        end
        // A query that would need many fresh loads falls back to the box test.
        if (!it.box_only && unloaded_count(it) > PRIME_BUDGET) it.box_only = 1'b1;
        if (!it.box_only) prime_overlap(it);
        send_command(it);
      end else begin
        send_command(noise_item());
      end
    end
  endtask

  // Main sequence.
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_LOAD_A;
    in_ch.pixel_index <= '0;
    in_ch.pixel_value <= '0;
    in_ch.pos_ax      <= '0;
    in_ch.pos_ay      <= '0;
    in_ch.pos_bx      <= '0;
    in_ch.pos_by      <= '0;
    in_ch.box_only    <= 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 47;
    solid_pct   = 50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset sizes of one pixel: overlap, touching edges,
    // separation, extreme placements, the unused code and stores outside
    // the mask area.
    send_command(load_item(CMD_LOAD_A, 0, 8'hFF));
    send_command(load_item(CMD_LOAD_B, 0, 8'h01));
    send_command(query_item(0, 0, 0, 0, 1'b0));
    send_command(query_item(0, 0, 0, 0, 1'b1));
    send_command(query_item(0, 0, 1, 0, 1'b0));
    send_command(query_item(0, 0, 1, 0, 1'b1));
    send_command(query_item(0, 0, 0, -1, 1'b1));
    send_command(query_item(0, 0, 2, 0, 1'b1));
    send_command(query_item(-32768, -32768, 32767, 32767, 1'b0));
    send_command(query_item(32767, 32767, -32768, -32768, 1'b1));
    send_command(query_item(32767, 32767, 32767, 32767, 1'b0));
    send_command(query_item(-32768, -32768, -32768, -32768, 1'b1));
    send_command(noise_item());
    send_command(load_item(CMD_LOAD_A, STORE_DEPTH - 1, 8'h80));
    send_command(load_item(CMD_LOAD_B, STORE_DEPTH - 1, 8'h00));
    send_command(load_item(CMD_LOAD_A, 0, 8'h00));
    send_command(query_item(5, 5, 5, 5, 1'b0));
    send_command(load_item(CMD_LOAD_A, 0, 8'h01));
    settle();

    // Zero width on A and a saturating width on B.
    program_sizes(0, 1, 127, 1);
    send_command(query_item(0, 0, 0, 0, 1'b0));
    send_command(query_item(0, 0, 0, 0, 1'b1));
    send_command(query_item(64, 0, 0, 0, 1'b1));
    send_command(query_item(65, 0, 0, 0, 1'b1));
    settle();

    // Random phases, each with its own mask sizes and pixel density.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 15;
        rx_idle_pct = 47;
      end else if (ph < 6) begin
        tx_idle_pct = 47;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      solid_pct = $urandom_range(3, 60);
      program_sizes(phase_size[ph][0], phase_size[ph][1], phase_size[ph][2],
                    phase_size[ph][3]);
      // Long result stall while commands keep coming, so the input backs up.
      if (ph == 2) rx_hold = 1'b1;
      random_traffic(phase_len[ph]);
      settle();
    end

    $display("Run covered %0d pixel loads, %0d collision queries and %0d unused-code commands,",
             sb.loads, sb.queries, sb.ignored);
    $display("with %0d results checked over %0d mask size settings and a long result stall.",
             sb.checked, size_settings);
    if (sb.errors == 0 && sb.pending_collides.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
